@@ hw/rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// operation codes, result widths and the front-to-back job record
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 31;
  // internal magnitude width, enough for a 32x32 product
  localparam int MAG_W     = 64;
  localparam int MAG_CW    = 7;

  // classified job handed from the front end to the back end
  typedef struct packed {
    logic [1:0]       op;
    logic             zdiv;
    logic [MAG_W-1:0] a;   // first gcd operand (magnitude)
    logic [MAG_W-1:0] b;   // second gcd operand (magnitude)
    logic             neg;
    logic [MAG_W-1:0] sn1; // add/sub: |n1|
    logic             s1;
    logic [MAG_W-1:0] sn2; // add/sub: |n2|
    logic             s2;
  } rau_job_t;

endpackage

@@ hw/rtl/rau_front.sv @@
// ----------------------------------------------------------------------------
// rau_front: accepts a request and classifies it
// forms products and magnitudes, then pushes one job into the queue
// ----------------------------------------------------------------------------
module rau_front
  import rau_pkg::*;
#(
  parameter int OW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic [1:0]     op,
  input  logic [OW-1:0]  n1_in,
  input  logic [OW-2:0]  d1_in,
  input  logic [OW-1:0]  n2_in,
  input  logic [OW-2:0]  d2_in,
  output logic           job_vld,
  output rau_job_t       job,
  input  logic           job_rdy
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_OUT  = 2'd2;

  logic [1:0]        st_r;
  logic [1:0]        op_r;
  logic [OW-1:0]     m1_r, m2_r;
  logic              s1_r, s2_r;
  logic [OW-2:0]     d1_r, d2_r;
  rau_job_t          job_r;

  logic [OW-1:0] m1, m2;
  logic [OW-2:0] d1, d2;
  logic [MAG_W-1:0] pa, pb;

  // magnitudes of the inputs, zero denominator read as one
  assign m1 = n1_in[OW-1] ? (~n1_in + 1'b1) : n1_in;
  assign m2 = n2_in[OW-1] ? (~n2_in + 1'b1) : n2_in;
  assign d1 = (d1_in == '0) ? {{(OW-2){1'b0}}, 1'b1} : d1_in;
  assign d2 = (d2_in == '0) ? {{(OW-2){1'b0}}, 1'b1} : d2_in;

  // one multiplier pair per product, registered before use
  always_comb begin
    pa = '0;
    pb = '0;
    if (op_r == OP_MUL) begin
      pa = MAG_W'(m1_r) * MAG_W'(m2_r);
      pb = MAG_W'(d1_r) * MAG_W'(d2_r);
    end else begin
      pa = MAG_W'(m1_r) * MAG_W'(d2_r);
      pb = MAG_W'(d1_r) * MAG_W'(m2_r);
    end
  end

  // classify and build job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      unique case (st_r)
        F_IDLE: if (take) st_r <= F_MUL;
        F_MUL:  st_r <= F_OUT;
        F_OUT:  if (job_rdy) st_r <= F_IDLE;
        default: st_r <= F_IDLE;
      endcase
    end
    if (take && st_r == F_IDLE) begin
      op_r <= op;
      m1_r <= m1;
      m2_r <= m2;
      s1_r <= n1_in[OW-1];
      s2_r <= n2_in[OW-1];
      d1_r <= d1;
      d2_r <= d2;
    end
    if (st_r == F_MUL) begin
      job_r.op   <= op_r;
      job_r.zdiv <= (op_r == OP_DIV) && (m2_r == '0);
      job_r.sn1  <= MAG_W'(m1_r);
      job_r.s1   <= s1_r;
      job_r.sn2  <= MAG_W'(m2_r);
      job_r.s2   <= s2_r;
      job_r.neg  <= s1_r ^ s2_r;
      if (op_r == OP_ADD || op_r == OP_SUB) begin
        job_r.a <= MAG_W'(d1_r);
        job_r.b <= MAG_W'(d2_r);
      end else begin
        job_r.a <= pa;
        job_r.b <= pb;
      end
    end
  end

  assign job_vld = (st_r == F_OUT);
  assign job     = job_r;

endmodule

@@ hw/rtl/rau_queue.sv @@
// ----------------------------------------------------------------------------
// rau_queue: two-entry queue between front and back end
// lets either side stall on its own
// ----------------------------------------------------------------------------
module rau_queue
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_vld,
  output logic     wr_rdy,
  input  rau_job_t wr_job,
  output logic     rd_vld,
  input  logic     rd_rdy,
  output rau_job_t rd_job
);

  rau_job_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_rdy = (cnt_r != 2'd2);
  assign rd_vld = (cnt_r != 2'd0);
  assign push   = wr_vld && wr_rdy;
  assign pop    = rd_vld && rd_rdy;
  assign rd_job = mem_r[rp_r];

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wr_job;
  end

endmodule

@@ hw/rtl/rau_divider.sv @@
// ----------------------------------------------------------------------------
// rau_divider: shared restoring divider, one quotient bit a cycle
// gives quotient and remainder of two magnitudes
// ----------------------------------------------------------------------------
module rau_divider
  import rau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [MAG_W-1:0] dvd,
  input  logic [MAG_W-1:0] dvs,
  output logic             done,
  output logic [MAG_W-1:0] quo,
  output logic [MAG_W-1:0] rem
);

  logic [MAG_W-1:0]  q_r, r_r, d_r;
  logic [MAG_CW-1:0] cnt_r;
  logic              run_r, done_r;
  logic [MAG_W:0]    trial;

  assign trial = {r_r, q_r[MAG_W-1]} - {1'b0, d_r};

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MAG_CW'(MAG_W-1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (go) begin
      q_r <= dvd;
      r_r <= '0;
      d_r <= dvs;
    end else if (run_r) begin
      if (!trial[MAG_W]) begin
        r_r <= trial[MAG_W-1:0];
        q_r <= {q_r[MAG_W-2:0], 1'b1};
      end else begin
        r_r <= {r_r[MAG_W-2:0], q_r[MAG_W-1]};
        q_r <= {q_r[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

@@ hw/rtl/rau_back.sv @@
// ----------------------------------------------------------------------------
// rau_back: carries out a job
// euclid gcd by repeated division, then scaling or reduction
// ----------------------------------------------------------------------------
module rau_back
  import rau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_vld,
  output logic                 job_rdy,
  input  rau_job_t             job,
  output logic                 out_vld,
  output logic [NUM_OUT_W-1:0] out_num,
  output logic [DEN_OUT_W-1:0] out_den,
  output logic                 out_st
);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_GCD  = 4'd1;
  localparam logic [3:0] B_GWT  = 4'd2;
  localparam logic [3:0] B_D1   = 4'd3;
  localparam logic [3:0] B_D1W  = 4'd4;
  localparam logic [3:0] B_D2   = 4'd5;
  localparam logic [3:0] B_D2W  = 4'd6;
  localparam logic [3:0] B_M1   = 4'd7;
  localparam logic [3:0] B_M2   = 4'd8;
  localparam logic [3:0] B_FIN  = 4'd9;

  logic [3:0]        st_r;
  rau_job_t          j_r;
  logic [MAG_W-1:0]  x_r, y_r, g_r, f1_r, f2_r;
  logic [MAG_W-1:0]  p1_r, p2_r;
  logic              go;
  logic [MAG_W-1:0]  dvd, dvs, quo, rem;
  logic              done;
  logic [MAG_W-1:0]  sumv, mag;
  logic              sneg;
  logic [MAG_W-1:0]  t1, t2;
  logic              addsub;
  logic [NUM_OUT_W-1:0] num_r;
  logic [DEN_OUT_W-1:0] den_r;
  logic                 st_r2, vld_r;

  rau_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .dvd  (dvd),
    .dvs  (dvs),
    .done (done),
    .quo  (quo),
    .rem  (rem)
  );

  assign addsub  = (j_r.op == OP_ADD) || (j_r.op == OP_SUB);
  assign job_rdy = (st_r == B_IDLE);

  // divider operand select
  always_comb begin
    go  = 1'b0;
    dvd = x_r;
    dvs = y_r;
    unique case (st_r)
      B_GCD: go = (y_r != '0);
      B_D1:  begin go = 1'b1; dvd = addsub ? j_r.b : j_r.a; dvs = g_r; end
      B_D2:  begin go = 1'b1; dvd = addsub ? j_r.a : j_r.b; dvs = g_r; end
      default: go = 1'b0;
    endcase
  end

  // signed combination of scaled numerators (low bits wrap as in two's complement)
  assign t1 = j_r.s1 ? (~p1_r + 1'b1) : p1_r;
  assign t2 = j_r.s2 ? (~p2_r + 1'b1) : p2_r;
  assign sumv = (j_r.op == OP_ADD) ? (t1 + t2) : (t1 - t2);
  assign sneg = j_r.neg && (f1_r != '0);
  assign mag  = sneg ? (~f1_r + 1'b1) : f1_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      vld_r <= 1'b0;
    end else begin
      vld_r <= 1'b0;
      unique case (st_r)
        B_IDLE: if (job_vld) st_r <= job.zdiv ? B_FIN : B_GCD;
        B_GCD:  if (y_r == '0) st_r <= B_D1; else st_r <= B_GWT;
        B_GWT:  if (done) st_r <= B_GCD;
        B_D1:   st_r <= B_D1W;
        B_D1W:  if (done) st_r <= B_D2;
        B_D2:   st_r <= B_D2W;
        B_D2W:  if (done) st_r <= addsub ? B_M1 : B_M2;
        B_M1:   st_r <= B_M2;
        B_M2:   st_r <= B_FIN;
        B_FIN:  begin st_r <= B_IDLE; vld_r <= 1'b1; end
        default: st_r <= B_IDLE;
      endcase
    end
    unique case (st_r)
      B_IDLE: if (job_vld) begin
        j_r <= job;
        x_r <= job.a;
        y_r <= job.b;
      end
      B_GCD: if (y_r == '0) g_r <= (x_r == '0) ? MAG_W'(1) : x_r;
      B_GWT: if (done) begin x_r <= y_r; y_r <= rem; end
      B_D1W: if (done) f1_r <= quo;
      B_D2W: if (done) f2_r <= quo;
      B_M1: begin
        // operands and scale factors fit in 32 bits
        p1_r <= j_r.sn1[31:0] * f1_r[31:0];
        p2_r <= j_r.sn2[31:0] * f2_r[31:0];
        f2_r <= j_r.a[31:0] * f1_r[31:0];
      end
      default: ;
    endcase
    // result forming
    if (st_r == B_M2) begin
      if (addsub) begin
        num_r <= sumv[NUM_OUT_W-1:0];
        den_r <= (sumv == '0) ? DEN_OUT_W'(1) : f2_r[DEN_OUT_W-1:0];
      end else begin
        num_r <= mag[NUM_OUT_W-1:0];
        den_r <= (f1_r == '0) ? DEN_OUT_W'(1) : f2_r[DEN_OUT_W-1:0];
      end
      st_r2 <= 1'b0;
    end else if (st_r == B_IDLE && job_vld && job.zdiv) begin
      num_r <= '0;
      den_r <= DEN_OUT_W'(1);
      st_r2 <= 1'b1;
    end
  end

  assign out_vld = vld_r;
  assign out_num = num_r;
  assign out_den = den_r;
  assign out_st  = st_r2;

endmodule

@@ hw/rtl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply, divide of two fractions
//
// Input: pulse start with in_req_type and the operands while busy is low;
// the beat is taken on that edge. Result: out_valid is high for one cycle
// with out_result_num, out_result_den and out_status; it must be taken then,
// the receiver cannot stall the unit.
// The front end registers the operands, forms products and magnitudes and
// hands a job through a two-entry queue to the back end. The back end runs
// the euclid gcd and two exact divisions on one 64-bit restoring divider at
// one quotient bit a cycle; the gcd loop on the shared divider sets the
// rate. Add and subtract take one more scaling state than multiply and
// divide, and a division by a zero fraction skips the divider. busy stays
// high until the result has been shown, so one item is in flight.
// Reset clears all control state; no result is pending after reset.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_req_type,
  input  logic [OPERAND_WIDTH-1:0] in_num_left,
  input  logic [OPERAND_WIDTH-2:0] in_den_left,
  input  logic [OPERAND_WIDTH-1:0] in_num_right,
  input  logic [OPERAND_WIDTH-2:0] in_den_right,
  output logic                     out_valid,
  output logic [NUM_OUT_W-1:0]     out_result_num,
  output logic [DEN_OUT_W-1:0]     out_result_den,
  output logic                     out_status
);

  logic     take, busy_r;
  logic     fj_vld, fj_rdy, bj_vld, bj_rdy;
  rau_job_t fj, bj;

  assign take = start && !busy_r;
  assign busy = busy_r;

  // one item in flight until its result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (take) begin
      busy_r <= 1'b1;
    end else if (out_valid) begin
      busy_r <= 1'b0;
    end
  end

  rau_front #(.OW(OPERAND_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .op     (in_req_type),
    .n1_in  (in_num_left),
    .d1_in  (in_den_left),
    .n2_in  (in_num_right),
    .d2_in  (in_den_right),
    .job_vld(fj_vld),
    .job    (fj),
    .job_rdy(fj_rdy)
  );

  rau_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_vld(fj_vld),
    .wr_rdy(fj_rdy),
    .wr_job(fj),
    .rd_vld(bj_vld),
    .rd_rdy(bj_rdy),
    .rd_job(bj)
  );

  rau_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .job_vld(bj_vld),
    .job_rdy(bj_rdy),
    .job    (bj),
    .out_vld(out_valid),
    .out_num(out_result_num),
    .out_den(out_result_den),
    .out_st (out_status)
  );

endmodule

@@ hw/rtl/rau_checker.sv @@
// ----------------------------------------------------------------------------
// rau_checker: port-level checks of the rational arithmetic unit
// result beats, busy and status consistency
// ----------------------------------------------------------------------------
module rau_checker
  import rau_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 busy,
  input logic                 out_valid,
  input logic [NUM_OUT_W-1:0] out_result_num,
  input logic [DEN_OUT_W-1:0] out_result_den,
  input logic                 out_status
);

  // a result beat only while an item is in flight
  a_vld_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without item");

  // busy drops right after the result beat
  a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy held after result");

  // denominator never zero
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_den != '0) else $error("zero denominator");

  // divide-by-zero gives 0/1
  a_zdiv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_result_num == '0 && out_result_den == 1))
    else $error("bad division by zero result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_result_num(out_result_num),
  .out_result_den(out_result_den),
  .out_status    (out_status)
);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the rational arithmetic unit
// drives add, subtract, multiply and divide beats with directed corners and
// random operands, predicts each fraction and checks every result beat
// ----------------------------------------------------------------------------
module tb;
  import rau_pkg::*;

  localparam int OW         = 16;
  localparam int IDLE_LIMIT = 40000;

  typedef struct packed {
    logic signed [NUM_OUT_W-1:0] num;
    logic [DEN_OUT_W-1:0]        den;
    logic                        status;
  } fraction_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_req_type = OP_ADD;
  logic [OW-1:0]        in_num_left = '0;
  logic [OW-2:0]        in_den_left = 15'd1;
  logic [OW-1:0]        in_num_right = '0;
  logic [OW-2:0]        in_den_right = 15'd1;
  logic                 out_valid;
  logic [NUM_OUT_W-1:0] out_result_num;
  logic [DEN_OUT_W-1:0] out_result_den;
  logic                 out_status;

  fraction_t pending_fractions[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        allow_gaps = 1'b1;

  rational_arithmetic_unit #(.OPERAND_WIDTH(OW)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_num_left(in_num_left),
    .in_den_left(in_den_left), .in_num_right(in_num_right),
    .in_den_right(in_den_right), .out_valid(out_valid),
    .out_result_num(out_result_num), .out_result_den(out_result_den),
    .out_status(out_status)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // euclid gcd on magnitudes, gcd(0, 0) taken as 1
  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return (x == 0) ? 1 : x;
  endfunction

  // expected fraction for one input beat
  function automatic fraction_t predict_fraction(logic [1:0] op, logic [OW-1:0] nl,
                                                 logic [OW-2:0] dl, logic [OW-1:0] nr,
                                                 logic [OW-2:0] dr);
    longint          n1, d1, n2, d2, num, den, f1, f2;
    longint unsigned mn, md, g;
    bit              neg;
    fraction_t       r;
    n1 = longint'($signed(nl));
    n2 = longint'($signed(nr));
    d1 = (dl == 0) ? 1 : longint'(dl);
    d2 = (dr == 0) ? 1 : longint'(dr);
    num = 0;
    den = 1;
    r.status = 1'b0;
    if (op == OP_ADD || op == OP_SUB) begin
      g = euclid_gcd(d1, d2);
      f1 = d2 / longint'(g);
      f2 = d1 / longint'(g);
      den = d1 * f1;
      num = (op == OP_ADD) ? n1 * f1 + n2 * f2 : n1 * f1 - n2 * f2;
    end else begin
      if (op == OP_MUL) begin
        num = n1 * n2;
        den = d1 * d2;
      end else if (n2 == 0) begin
        r.status = 1'b1;
      end else begin
        num = n1 * d2;
        den = d1 * n2;
      end
      if (!r.status) begin
        neg = (num < 0) != (den < 0);
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        g = euclid_gcd(mn, md);
        mn = mn / g;
        md = md / g;
        num = neg ? -longint'(mn) : longint'(mn);
        den = longint'(md);
      end
    end
    if (num == 0) den = 1;
    r.num = num[NUM_OUT_W-1:0];
    r.den = den[DEN_OUT_W-1:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    fraction_t exp_f;
    if (rst_n && out_valid) begin
      if (pending_fractions.size() == 0) begin
        $error("unexpected result beat num=%0d den=%0d", $signed(out_result_num),
               out_result_den);
        errors++;
      end else begin
        exp_f = pending_fractions.pop_front();
        if (out_result_num !== exp_f.num) begin
          $error("result_num expected %0d actual %0d", exp_f.num, $signed(out_result_num));
          errors++;
        end
        if (out_result_den !== exp_f.den) begin
          $error("result_den expected %0d actual %0d", exp_f.den, out_result_den);
          errors++;
        end
        if (out_status !== exp_f.status) begin
          $error("status expected %0d actual %0d", exp_f.status, out_status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // one input beat; start stays high on return unless a random gap follows
  task automatic send_fraction_pair(logic [1:0] op, logic [OW-1:0] nl, logic [OW-2:0] dl,
                                    logic [OW-1:0] nr, logic [OW-2:0] dr);
    in_req_type  <= op;
    in_num_left  <= nl;
    in_den_left  <= dl;
    in_num_right <= nr;
    in_den_right <= dr;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_fractions.push_back(predict_fraction(op, nl, dl, nr, dr));
    // random gap after the beat
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // operand with bias to corners
  function automatic logic [OW-1:0] pick_num();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 16)) - 8);
      4: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [OW-2:0] pick_den();
    case ($urandom_range(0, 7))
      0: return 15'h7fff;
      1: return 15'd0;
      2: return 15'd1;
      3: return 15'($urandom_range(1, 12));
      4: return 15'($urandom_range(1, 255));
      default: return 15'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_fraction_pair(OP_ADD, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7ffe);
    send_fraction_pair(OP_ADD, 16'h8000, 15'd1, 16'h8000, 15'd1);
    send_fraction_pair(OP_ADD, 16'd3, 15'd4, 16'hfffd, 15'd4);   // zero sum
    send_fraction_pair(OP_ADD, 16'd1, 15'd0, 16'd1, 15'd0);      // zero denominators
    send_fraction_pair(OP_SUB, 16'h8000, 15'h7fff, 16'h7fff, 15'h7ffe);
    send_fraction_pair(OP_SUB, 16'd5, 15'd6, 16'd5, 15'd6);
    send_fraction_pair(OP_SUB, 16'h7fff, 15'd6, 16'h8000, 15'd10);
    send_fraction_pair(OP_MUL, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
    send_fraction_pair(OP_MUL, 16'h7fff, 15'd1, 16'h8000, 15'd1);
    send_fraction_pair(OP_MUL, 16'h0000, 15'd9, 16'hffff, 15'd3);
    send_fraction_pair(OP_MUL, 16'd6, 15'd0, 16'hfff6, 15'd4);
    send_fraction_pair(OP_DIV, 16'd7, 15'd3, 16'h0000, 15'd5);   // divide by zero
    send_fraction_pair(OP_DIV, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
    send_fraction_pair(OP_DIV, 16'h7fff, 15'd1, 16'hffff, 15'h7fff);
    send_fraction_pair(OP_DIV, 16'h0000, 15'd2, 16'd3, 15'd0);
    send_fraction_pair(OP_DIV, 16'hfffc, 15'd6, 16'hfff8, 15'd9);
  endtask

  task automatic test_random(int n);
    repeat (n) begin
      send_fraction_pair(2'($urandom_range(0, 3)), pick_num(), pick_den(), pick_num(),
                         pick_den());
    end
  endtask

  task automatic test_no_gaps(int n);
    allow_gaps = 1'b0;
    test_random(n);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(420);
    test_no_gaps(80);
    start <= 1'b0;
    // drain: watchdog bounds this wait
    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
